// ----- rtl/qdc_pkg.sv -----
// Shared types and constants for the quadrature detent counter.
package qdc_pkg;

	localparam int POS_W    = 32;
	localparam int ACC_W    = 4;
	localparam int CFG_IDX_W = 2;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MIN_POSITION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POSITION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_ENABLE = 2'd2;

	// Request kinds
	localparam logic CMD_PIN_SAMPLE = 1'b0;
	localparam logic CMD_LOAD       = 1'b1;

	// Reset values
	localparam logic [1:0]              AB_RESET  = 2'b11;
	localparam logic signed [POS_W-1:0] MIN_RESET = 32'sh8000_0000;
	localparam logic signed [POS_W-1:0] MAX_RESET = 32'sh7FFF_FFFF;

	// Accumulator values that complete a detent
	localparam logic signed [ACC_W-1:0] ACC_UP_LIMIT   = 4'sd4;
	localparam logic signed [ACC_W-1:0] ACC_DOWN_LIMIT = -4'sd4;

	// Transition table indexed by {old_ab, new_ab}
	localparam logic signed [1:0] TRANS_TABLE [16] = '{
		2'sd0,  -2'sd1, 2'sd1,  2'sd0,
		2'sd1,  2'sd0,  2'sd0,  -2'sd1,
		-2'sd1, 2'sd0,  2'sd0,  2'sd1,
		2'sd0,  2'sd1,  -2'sd1, 2'sd0
	};

	// Outcome of decoding one pin sample
	typedef struct packed {
		logic                    detent;
		logic                    up;
		logic signed [ACC_W-1:0] acc_next;
		logic [1:0]              ab_next;
	} step_t;

endpackage

// ----- rtl/qdc_step.sv -----
// Transition decode and step accumulator update for one pin sample.
module qdc_step (
	input  logic                            active,
	input  logic [1:0]                      prev_ab,
	input  logic signed [qdc_pkg::ACC_W-1:0] acc,
	input  logic                            pin_a,
	input  logic                            pin_b,
	output qdc_pkg::step_t                  step
);

	logic [3:0]                       idx;
	logic signed [qdc_pkg::ACC_W-1:0] sum;
	logic                             hit_up;
	logic                             hit_down;

	assign idx      = {prev_ab, pin_a, pin_b};
	assign sum      = acc + qdc_pkg::ACC_W'(qdc_pkg::TRANS_TABLE[idx]);
	assign hit_up   = (sum == qdc_pkg::ACC_UP_LIMIT);
	assign hit_down = (sum == qdc_pkg::ACC_DOWN_LIMIT);

	always_comb begin
		step.detent   = active && (hit_up || hit_down);
		step.up       = hit_up;
		step.ab_next  = active ? {pin_a, pin_b} : prev_ab;
		if (!active) begin
			step.acc_next = acc;
		end else if (hit_up || hit_down) begin
			step.acc_next = '0;
		end else begin
			step.acc_next = sum;
		end
	end

endmodule

// ----- rtl/qdc_wrap.sv -----
// Next position: load or detent step, then wrap into [min, max].
module qdc_wrap (
	input  logic                             load,
	input  logic signed [qdc_pkg::POS_W-1:0] load_value,
	input  logic signed [qdc_pkg::POS_W-1:0] cur_pos,
	input  qdc_pkg::step_t                   step,
	input  logic signed [qdc_pkg::POS_W-1:0] min_pos,
	input  logic signed [qdc_pkg::POS_W-1:0] max_pos,
	output logic signed [qdc_pkg::POS_W-1:0] next_pos
);

	// one bit wider so the step cannot overflow before the wrap
	logic signed [qdc_pkg::POS_W:0] inc;
	logic signed [qdc_pkg::POS_W:0] raw;
	logic signed [qdc_pkg::POS_W:0] lo;
	logic signed [qdc_pkg::POS_W:0] hi;

	always_comb begin
		if (!step.detent) begin
			inc = '0;
		end else if (step.up) begin
			inc = (qdc_pkg::POS_W+1)'(1);
		end else begin
			inc = '1;
		end
		if (load) begin
			raw = (qdc_pkg::POS_W+1)'(load_value);
		end else begin
			raw = (qdc_pkg::POS_W+1)'(cur_pos) + inc;
		end
		lo = (qdc_pkg::POS_W+1)'(min_pos);
		hi = (qdc_pkg::POS_W+1)'(max_pos);
		if (raw < lo) begin
			next_pos = max_pos;
		end else if (raw > hi) begin
			next_pos = min_pos;
		end else begin
			next_pos = raw[qdc_pkg::POS_W-1:0];
		end
	end

endmodule

// ----- rtl/quadrature_detent_counter.sv -----
// Top level of the quadrature detent counter.
//
// Usage:
//   Requests enter on the s_ stream. s_tuser is the kind: 0 = pin sample,
//   1 = load position. A pin sample is decoded 4x against the previous A/B
//   pair; four steps in one direction make a detent and move the position
//   by one. A load sets the position from load_value. After every request
//   the position wraps into [min_position, max_position].
//   Each request gives one result on the m_ stream: position on m_tdata and
//   the detent flag on m_tuser.
// Timing:
//   A request is held in the input register, then decoded and stored in the result register.
//   One request per cycle is sustained while m_tready stays high; the rate is set by the single
//   decode/add/wrap pass between the input register and the result register.
// Reset: arst_n clears both stages, A/B pair to both-high, accumulator and
//   position to 0, and the registers to full range with counting enabled.
// Stall: when m_tready is low the result holds, the input register keeps one
//   more request, and s_tready drops once both are full.
// Configuration: write with cfg_we only while the block is idle.
module quadrature_detent_counter (
	input  logic                           clk,
	input  logic                           arst_n,
	// request stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [39:0]                    s_tdata,   // [0] pin_a, [1] pin_b, [33:2] load_value
	input  logic                           s_tuser,   // [0] cmd
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,   // [31:0] position
	output logic                           m_tuser,   // [0] detent_seen
	// configuration
	input  logic                           cfg_we,
	input  logic [qdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);

	// configuration registers
	logic signed [qdc_pkg::POS_W-1:0] min_pos_q;
	logic signed [qdc_pkg::POS_W-1:0] max_pos_q;
	logic                             count_en_q;

	// decoder state
	logic [1:0]                       prev_ab_q;
	logic signed [qdc_pkg::ACC_W-1:0] acc_q;
	logic signed [qdc_pkg::POS_W-1:0] pos_q;

	// input register
	logic                             valid_s1;
	logic                             cmd_s1;
	logic                             pin_a_s1;
	logic                             pin_b_s1;
	logic signed [qdc_pkg::POS_W-1:0] load_s1;

	// result register
	logic                             out_valid_q;
	logic signed [qdc_pkg::POS_W-1:0] out_pos_q;
	logic                             out_detent_q;

	logic                             out_free;
	logic                             advance;
	logic                             s_accept;
	qdc_pkg::step_t                   step;
	logic signed [qdc_pkg::POS_W-1:0] next_pos;

	// result register can take a new value when empty or being drained
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pos_q  <= qdc_pkg::MIN_RESET;
			max_pos_q  <= qdc_pkg::MAX_RESET;
			count_en_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				qdc_pkg::REG_MIN_POSITION: min_pos_q  <= cfg_data;
				qdc_pkg::REG_MAX_POSITION: max_pos_q  <= cfg_data;
				qdc_pkg::REG_COUNT_ENABLE: count_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1   <= s_tuser;
			pin_a_s1 <= s_tdata[0];
			pin_b_s1 <= s_tdata[1];
			load_s1  <= s_tdata[33:2];
		end
	end

	qdc_step u_step (
		.active  (cmd_s1 == qdc_pkg::CMD_PIN_SAMPLE && count_en_q),
		.prev_ab (prev_ab_q),
		.acc     (acc_q),
		.pin_a   (pin_a_s1),
		.pin_b   (pin_b_s1),
		.step    (step)
	);

	qdc_wrap u_wrap (
		.load       (cmd_s1 == qdc_pkg::CMD_LOAD),
		.load_value (load_s1),
		.cur_pos    (pos_q),
		.step       (step),
		.min_pos    (min_pos_q),
		.max_pos    (max_pos_q),
		.next_pos   (next_pos)
	);

	// state commits as the request moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ab_q <= qdc_pkg::AB_RESET;
			acc_q     <= '0;
			pos_q     <= '0;
		end else if (advance) begin
			prev_ab_q <= step.ab_next;
			acc_q     <= step.acc_next;
			pos_q     <= next_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_pos_q    <= next_pos;
			out_detent_q <= step.detent;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pos_q;
	assign m_tuser  = out_detent_q;

	// accumulator never rests at a detent value
	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q != qdc_pkg::ACC_UP_LIMIT && acc_q != qdc_pkg::ACC_DOWN_LIMIT)
		else $error("step accumulator left its range");

	// a load never reports a detent
	a_load_no_detent: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd_s1 == qdc_pkg::CMD_LOAD |=> !out_detent_q)
		else $error("detent reported on a load");

	// decoder state only moves when a request commits
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(prev_ab_q) && $stable(acc_q) && $stable(pos_q))
		else $error("decoder state changed without a request");

	// both stages full and stalled: no new request taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_tready |-> !s_tready)
		else $error("request accepted into a full pipeline");

	// every result comes with the position register updated to it
	a_result_matches: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_pos_q == pos_q)
		else $error("result position differs from stored position");

endmodule

// ----- dv/qdc_count_checker.sv -----
// Checker for the quadrature detent counter: predicts each position report and compares.
`timescale 1ns / 100ps

module qdc_count_checker
	import qdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // [0] pin_a, [1] pin_b, [33:2] load_value
	input  logic        s_tuser,   // [0] cmd
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [31:0] position
	input  logic        m_tuser,   // [0] detent_seen
	input  logic        cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	output int          mismatches,
	output int          outstanding
);

	typedef struct {
		logic signed [31:0] position;
		logic               detent;
	} count_report_t;

	count_report_t      reports_due[$];
	count_report_t      got;
	logic [1:0]         last_ab;
	int                 step_sum;
	logic signed [31:0] position_now;
	logic signed [31:0] lo_limit;
	logic signed [31:0] hi_limit;
	logic               count_on;

	// next A/B pair when turning in the counting-up direction: 11 -> 01 -> 00 -> 10 -> 11
	function automatic logic [1:0] ab_up(input logic [1:0] ab);
		case (ab)
			2'b11:   return 2'b01;
			2'b01:   return 2'b00;
			2'b00:   return 2'b10;
			default: return 2'b11;
		endcase
	endfunction

	function automatic void count_request(input logic kind, input logic [1:0] ab,
			input logic signed [31:0] load_value);
		logic signed [32:0] next_pos;
		count_report_t      rep;
		next_pos   = position_now;
		rep.detent = 1'b0;
		if (kind == CMD_LOAD) begin
			next_pos = load_value;
		end else if (count_on) begin
			// one quarter step per valid edge; diagonal jumps and repeats count nothing
			if (ab == ab_up(last_ab))
				step_sum = step_sum + 1;
			else if (last_ab == ab_up(ab))
				step_sum = step_sum - 1;
			last_ab = ab;
			if (step_sum > 3) begin
				next_pos   = next_pos + 33'sd1;
				rep.detent = 1'b1;
			end else if (step_sum < -3) begin
				next_pos   = next_pos - 33'sd1;
				rep.detent = 1'b1;
			end
			if (rep.detent)
				step_sum = 0;
		end
		// wrap applies after every request, min checked first
		if (next_pos < lo_limit)
			next_pos = hi_limit;
		else if (next_pos > hi_limit)
			next_pos = lo_limit;
		position_now = next_pos[31:0];
		rep.position = position_now;
		reports_due.push_back(rep);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ab      = AB_RESET;
			step_sum     = 0;
			position_now = '0;
			lo_limit     = MIN_RESET;
			hi_limit     = MAX_RESET;
			count_on     = 1'b1;
			reports_due.delete();
			outstanding  = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_POSITION: lo_limit = cfg_data;
					REG_MAX_POSITION: hi_limit = cfg_data;
					REG_COUNT_ENABLE: count_on = cfg_data[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				count_request(s_tuser, {s_tdata[0], s_tdata[1]}, s_tdata[33:2]);
			if (m_tvalid && m_tready) begin
				if (reports_due.size() == 0) begin
					$error("unexpected result: position %0d detent_seen %0b",
						$signed(m_tdata), m_tuser);
					mismatches++;
				end else begin
					got = reports_due.pop_front();
					if (m_tdata !== got.position) begin
						$error("position: expected %0d, actual %0d",
							got.position, $signed(m_tdata));
						mismatches++;
					end
					if (m_tuser !== got.detent) begin
						$error("detent_seen: expected %0b, actual %0b", got.detent, m_tuser);
						mismatches++;
					end
				end
			end
			outstanding = reports_due.size();
		end
	end

endmodule

// ----- dv/tb_quadrature_detent_counter.sv -----
// Testbench top for the quadrature detent counter: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_quadrature_detent_counter;
	import qdc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 64;    // receiver hold-off, well past the two-deep pipe

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = '0;   // [0] pin_a, [1] pin_b, [33:2] load_value
	logic        s_tuser   = 1'b0; // [0] cmd
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;          // [31:0] position
	logic        m_tuser;          // [0] detent_seen
	logic        cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data  = '0;

	int mismatches;
	int outstanding;

	always #6 clk = ~clk;

	quadrature_detent_counter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	qdc_count_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Registered copy of the request handshake, read back at the falling edge so the
	// sender never races the block's own updates of s_tready.
	logic request_taken;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			request_taken <= 1'b0;
		else
			request_taken <= s_tvalid && s_tready;
	end

	// ---------------------------------------------------------------------------------
	// Receiver: a rotating 16-bit ready pattern, reshuffled whenever the low six bits of its
	// phase counter wrap, plus a long hold-off whenever the stimulus asks for one.
	// ---------------------------------------------------------------------------------
	int          long_holds_asked = 0;
	int          long_holds_done  = 0;
	int          hold_left        = 0;
	int          stall_phase      = 0;
	logic [15:0] ready_pattern    = 16'hFFFF;

	always @(negedge clk) begin
		if (long_holds_done != long_holds_asked) begin
			long_holds_done <= long_holds_asked;
			hold_left       <= LONG_HOLD;
			m_tready        <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready    <= ready_pattern[stall_phase[3:0]];
			stall_phase <= stall_phase + 1;
			if (stall_phase[5:0] == 6'd63) begin
				case ($urandom_range(0, 3))
					0: ready_pattern <= 16'hFFFF;                      // no stalls
					1: ready_pattern <= 16'($urandom);
					2: ready_pattern <= 16'($urandom) | 16'($urandom); // mostly ready
					default: ready_pattern <= 16'($urandom) & 16'($urandom);
				endcase
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Sender
	// ---------------------------------------------------------------------------------
	logic [1:0]         pins_now  = 2'b11;  // last A/B pair offered, tracks the encoder
	logic signed [31:0] lo_set    = MIN_RESET;
	logic signed [31:0] hi_set    = MAX_RESET;
	int                 burst_left = 0;
	int                 gap_max    = 5;

	function automatic logic [1:0] gray_step(input logic [1:0] ab, input logic up);
		if (up) begin
			case (ab)
				2'b11:   return 2'b01;
				2'b01:   return 2'b00;
				2'b00:   return 2'b10;
				default: return 2'b11;
			endcase
		end else begin
			case (ab)
				2'b11:   return 2'b10;
				2'b10:   return 2'b00;
				2'b00:   return 2'b01;
				default: return 2'b11;
			endcase
		end
	endfunction

	// Offer one request and hold it until accepted. Entered and left at a falling edge.
	// ab is {pin_a, pin_b}.
	task automatic send_request(input logic kind, input logic [1:0] ab,
			input logic [31:0] load_value);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (gap_max != 0 && $urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {6'd0, load_value, ab[0], ab[1]};
		do @(negedge clk); while (!request_taken);
		if (kind == CMD_PIN_SAMPLE)
			pins_now = ab;
	endtask

	task automatic send_pins(input logic [1:0] ab);
		send_request(CMD_PIN_SAMPLE, ab, $urandom);
	endtask

	task automatic send_load(input logic [31:0] value);
		send_request(CMD_LOAD, 2'($urandom), value);
	endtask

	// Stop offering and wait until every report has come back, then let the pipe settle.
	task automatic drain;
		s_tvalid  <= 1'b0;
		burst_left = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MIN_POSITION)
			lo_set = value;
		else if (idx == REG_MAX_POSITION)
			hi_set = value;
	endtask

	// Load targets lean on the wrap limits and the values just past them.
	function automatic logic [31:0] pick_load();
		case ($urandom_range(0, 6))
			0: return lo_set;
			1: return hi_set;
			2: return lo_set - 32'd1;
			3: return hi_set + 32'd1;
			4: return 32'($urandom_range(0, 20)) - 32'd10;
			default: return $urandom;
		endcase
	endfunction

	// A turn of the knob: mostly clean quarter steps one way, with some bounce,
	// repeated samples and illegal diagonal jumps mixed in.
	task automatic turn_knob(input int steps);
		logic       up;
		logic [1:0] ab;
		int         r;
		up = 1'($urandom_range(0, 1));
		repeat (steps) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				ab = gray_step(pins_now, up);
			else if (r < 88)
				ab = gray_step(pins_now, !up);
			else if (r < 94)
				ab = pins_now;
			else
				ab = pins_now ^ 2'b11;
			send_pins(ab);
		end
	endtask

	task automatic random_traffic(input int n);
		int sent;
		int run;
		int r;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				send_load(pick_load());
				sent++;
			end else if (r < 16) begin
				send_pins(2'($urandom));
				sent++;
			end else begin
				run = $urandom_range(1, 12);
				if (run > n - sent)
					run = n - sent;
				turn_knob(run);
				sent += run;
			end
		end
	endtask

	// ---------------------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------------------
	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset limits: full 32-bit range. One detent up from the top wraps to the bottom,
		// one detent down from the bottom wraps to the top.
		send_load(32'h7FFF_FFFF);
		send_pins(2'b01);
		send_pins(2'b00);
		send_pins(2'b10);
		send_pins(2'b11);
		send_load(32'h8000_0000);
		send_pins(2'b10);
		send_pins(2'b00);
		send_pins(2'b01);
		send_pins(2'b11);
		// diagonal jumps count nothing, nor does a repeated sample
		send_pins(2'b00);
		send_pins(2'b11);
		send_pins(2'b11);
		// a quarter step and back leaves the step sum at zero
		send_pins(2'b01);
		send_pins(2'b11);
		send_load(32'hFFFF_FFFF);
		send_load(32'h0000_0000);

		random_traffic(200);

		// Long receiver hold-off against back-to-back requests: the pipe fills and
		// s_tready must drop.
		long_holds_asked <= long_holds_asked + 1;
		gap_max = 0;
		random_traffic(30);
		gap_max = 5;

		drain;
		random_traffic(60);

		// Narrow window; loads outside it wrap, detents wrap at both ends.
		drain;
		write_reg(REG_MIN_POSITION, -32'sd5);
		write_reg(REG_MAX_POSITION, 32'sd5);
		write_reg(REG_COUNT_ENABLE, 32'd1);
		send_load(32'd100);
		send_load(-32'sd100);
		send_load(32'd5);
		turn_knob(8);
		random_traffic(120);

		// Counting off: pin samples change nothing, loads still land.
		drain;
		write_reg(REG_COUNT_ENABLE, 32'd0);
		random_traffic(40);
		drain;
		write_reg(REG_COUNT_ENABLE, 32'd1);

		// Minimum above maximum
		write_reg(REG_MIN_POSITION, 32'sd10);
		write_reg(REG_MAX_POSITION, 32'sd3);
		random_traffic(50);

		// Single-value windows at both ends of the range
		drain;
		write_reg(REG_MIN_POSITION, 32'h7FFF_FFFF);
		write_reg(REG_MAX_POSITION, 32'h7FFF_FFFF);
		random_traffic(30);
		drain;
		write_reg(REG_MIN_POSITION, 32'h8000_0000);
		write_reg(REG_MAX_POSITION, 32'h8000_0000);
		random_traffic(30);

		// Back to the full range
		drain;
		write_reg(REG_MAX_POSITION, 32'h7FFF_FFFF);
		random_traffic(80);

		drain;
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog
	int cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule

// ----- quadrature_detent_counter.f -----
rtl/qdc_pkg.sv
rtl/qdc_step.sv
rtl/qdc_wrap.sv
rtl/quadrature_detent_counter.sv
dv/qdc_count_checker.sv
dv/tb_quadrature_detent_counter.sv
